/* sv/efd_pkg.sv */
package efd_pkg;

  localparam logic [7:0] START_BYTE  = 8'hE0;
  localparam logic [7:0] ESCAPE_BYTE = 8'hD0;

  localparam logic [7:0] EXEMPT_CMD_RESET = 8'd99;
  localparam logic [7:0] CMD_POS_RESET    = 8'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_EXEMPT   = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_e;

  typedef enum logic {
    CFG_EXEMPT_CMD = 1'b0,
    CFG_CMD_POS    = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
    status_e    status;
  } efd_result_t;

endpackage

/* sv/efd_decoder.sv */
module efd_decoder
  import efd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        beat_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  exempt_cmd_i,
  input  logic [7:0]  cmd_pos_i,
  output efd_result_t result_o
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2,
    PH_CHECK  = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        esc_q, esc_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic        exempt_q, exempt_d;
  logic [7:0]  dec_byte;
  logic [7:0]  pos_inc;
  efd_result_t res;

  assign dec_byte = esc_q ? rx_byte_i + 8'd1 : rx_byte_i;
  assign pos_inc  = pos_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    esc_d    = esc_q;
    pos_d    = pos_q;
    len_d    = len_q;
    sum_d    = sum_q;
    exempt_d = exempt_q;
    res      = '{valid: 1'b0, data: rx_byte_i, index: 8'd0, last: 1'b0, status: ST_OK};
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == START_BYTE) begin
          phase_d  = PH_LENGTH;
          esc_d    = 1'b0;
          pos_d    = 8'd0;
          len_d    = 8'd0;
          sum_d    = 8'd0;
          exempt_d = 1'b0;
        end
      end
      PH_LENGTH: begin
        len_d     = rx_byte_i;
        sum_d     = rx_byte_i;
        esc_d     = 1'b0;
        exempt_d  = 1'b0;
        res.valid = 1'b1;
        if (rx_byte_i == 8'd0) begin
          res.last   = 1'b1;
          res.status = ST_ZERO_LEN;
          phase_d    = PH_HUNT;
          pos_d      = 8'd0;
        end else begin
          pos_d   = 8'd1;
          phase_d = (rx_byte_i == 8'd1) ? PH_CHECK : PH_BODY;
        end
      end
      PH_BODY: begin
        if (rx_byte_i == ESCAPE_BYTE) begin
          esc_d = 1'b1;
        end else begin
          esc_d = 1'b0;
          sum_d = sum_q + dec_byte;
          if (pos_q == cmd_pos_i && dec_byte == exempt_cmd_i) exempt_d = 1'b1;
          res.valid = 1'b1;
          res.data  = dec_byte;
          res.index = pos_q;
          pos_d     = pos_inc;
          if (pos_inc == len_q) phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (rx_byte_i == ESCAPE_BYTE) begin
          esc_d = 1'b1;
        end else begin
          res.valid = 1'b1;
          res.data  = dec_byte;
          res.index = len_q;
          res.last  = 1'b1;
          if (exempt_q)                res.status = ST_EXEMPT;
          else if (dec_byte == sum_q)  res.status = ST_OK;
          else                         res.status = ST_CSUM_ERR;
          phase_d  = PH_HUNT;
          esc_d    = 1'b0;
          pos_d    = 8'd0;
          len_d    = 8'd0;
          sum_d    = 8'd0;
          exempt_d = 1'b0;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
    if (!beat_i) res.valid = 1'b0;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      esc_q    <= 1'b0;
      pos_q    <= 8'd0;
      len_q    <= 8'd0;
      sum_q    <= 8'd0;
      exempt_q <= 1'b0;
    end else if (beat_i) begin
      phase_q  <= phase_d;
      esc_q    <= esc_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      exempt_q <= exempt_d;
    end
  end

endmodule

/* sv/escaped_frame_deframer.sv */
// Latency: a result beat appears on the master side in the cycle after the input beat.
// Throughput: one input beat per cycle while the master side does not stall; the output register takes a new result
// in the same cycle that the previous one is taken.
// Reset: asynchronous active low; hunts for a start byte, registers return to
// exempt command 99 and command position 3, output invalid.
module escaped_frame_deframer
  import efd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [1:0] frame_status
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]  exempt_cmd_q;
  logic [7:0]  cmd_pos_q;
  logic        in_beat;
  efd_result_t result;
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        out_last_q;
  status_e     out_status_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exempt_cmd_q <= EXEMPT_CMD_RESET;
      cmd_pos_q    <= CMD_POS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_EXEMPT_CMD: exempt_cmd_q <= cfg_data_i;
        CFG_CMD_POS:    cmd_pos_q    <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  efd_decoder u_decoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (in_beat),
    .rx_byte_i    (s_axis_tdata),
    .exempt_cmd_i (exempt_cmd_q),
    .cmd_pos_i    (cmd_pos_q),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result.valid && s_axis_tready) begin
      out_data_q   <= {result.index, result.data};
      out_last_q   <= result.last;
      out_status_q <= result.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule

/* sv/efd_checker.sv */
module efd_checker
  import efd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  a_status_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == ST_OK)
    else $error("status set on a beat that does not close the frame");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast && m_axis_tuser == ST_ZERO_LEN
      |-> m_axis_tdata == 16'd0)
    else $error("zero length frame closed with wrong data or index");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast && m_axis_tdata[15:8] == 8'd0
      |-> m_axis_tdata[7:0] != 8'd0)
    else $error("open frame started with a zero length byte");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

endmodule

bind escaped_frame_deframer efd_checker u_efd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

/* tb/escaped_frame_deframer_tb.sv */
`timescale 1ns / 1ps

module escaped_frame_deframer_tb;
  import efd_pkg::*;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_LENGTH,
    RX_BODY,
    RX_CHECKSUM
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] index;
    logic       last;
    status_e    status;
  } frame_beat_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        pinned;
    logic        pin_has;
    frame_beat_t pin_beat;
  } rx_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  escaped_frame_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // predictor copy of registers and frame state
  logic [7:0] exempt_cmd_q;
  logic [7:0] cmd_pos_q;
  rx_phase_e  rx_phase_q;
  logic       esc_q;
  logic [7:0] pos_q;
  logic [7:0] len_q;
  logic [7:0] sum_q;
  logic       exempt_q;

  rx_item_t    rx_feed[$];
  frame_beat_t pending_beats[$];

  int  mismatches = 0;
  int  beats_in = 0;
  int  beats_out = 0;
  int  settings_used = 1;
  int  ends_by_status[4] = '{0, 0, 0, 0};
  bit  tx_burst = 0;
  bit  rx_burst = 0;
  bit  hold_off_req = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic restart_hunt();
    rx_phase_q = RX_HUNT;
    esc_q      = 1'b0;
    pos_q      = 8'd0;
    len_q      = 8'd0;
    sum_q      = 8'd0;
    exempt_q   = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, output logic has, output frame_beat_t r);
    logic [7:0] v;
    has = 1'b0;
    r   = '0;
    v   = esc_q ? b + 8'd1 : b;
    case (rx_phase_q)
      RX_HUNT: begin
        if (b == START_BYTE) begin
          restart_hunt();
          rx_phase_q = RX_LENGTH;
        end
      end
      RX_LENGTH: begin
        len_q    = b;
        sum_q    = b;
        esc_q    = 1'b0;
        exempt_q = 1'b0;
        has      = 1'b1;
        r.data   = b;
        r.index  = 8'd0;
        r.status = ST_OK;
        if (b == 8'd0) begin
          r.last   = 1'b1;
          r.status = ST_ZERO_LEN;
          restart_hunt();
        end else begin
          pos_q      = 8'd1;
          rx_phase_q = (b == 8'd1) ? RX_CHECKSUM : RX_BODY;
        end
      end
      RX_BODY: begin
        if (b == ESCAPE_BYTE) begin
          esc_q = 1'b1;
        end else begin
          esc_q = 1'b0;
          sum_q = sum_q + v;
          if (pos_q == cmd_pos_q && v == exempt_cmd_q) exempt_q = 1'b1;
          has      = 1'b1;
          r.data   = v;
          r.index  = pos_q;
          r.status = ST_OK;
          pos_q    = pos_q + 8'd1;
          if (pos_q == len_q) rx_phase_q = RX_CHECKSUM;
        end
      end
      default: begin
        if (b == ESCAPE_BYTE) begin
          esc_q = 1'b1;
        end else begin
          has     = 1'b1;
          r.data  = v;
          r.index = len_q;
          r.last  = 1'b1;
          if (exempt_q) r.status = ST_EXEMPT;
          else if (v == sum_q) r.status = ST_OK;
          else r.status = ST_CSUM_ERR;
          restart_hunt();
        end
      end
    endcase
  endtask

  function automatic rx_item_t plain(input logic [7:0] b);
    rx_item_t it;
    it    = '0;
    it.rx = b;
    return it;
  endfunction

  function automatic rx_item_t pinned(input logic [7:0] b, input logic has,
                                      input logic [7:0] data, input logic [7:0] idx,
                                      input logic last, input status_e st);
    rx_item_t it;
    it                 = '0;
    it.rx              = b;
    it.pinned          = 1'b1;
    it.pin_has         = has;
    it.pin_beat.data   = data;
    it.pin_beat.index  = idx;
    it.pin_beat.last   = last;
    it.pin_beat.status = st;
    return it;
  endfunction

  task automatic set_reg(input cfg_index_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CFG_EXEMPT_CMD) exempt_cmd_q = val;
    else cmd_pos_q = val;
  endtask

  task automatic send_feed();
    rx_item_t    it;
    logic        has;
    frame_beat_t r;
    int          gap;
    while (rx_feed.size() > 0) begin
      it  = rx_feed.pop_front();
      gap = tx_burst ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      @(negedge clk_i);
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.rx;
      do @(posedge clk_i); while (!s_axis_tready);
      beats_in++;
      deframe_byte(it.rx, has, r);
      if (it.pinned) begin
        has = it.pin_has;
        r   = it.pin_beat;
      end
      if (has) pending_beats.push_back(r);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // escape a decoded value; D1 stays raw since D0 D0 would re-escape
  task automatic push_coded(input logic [7:0] v);
    if (v == ESCAPE_BYTE || (v != ESCAPE_BYTE + 8'd1 && $urandom_range(0, 7) == 0)) begin
      if ($urandom_range(0, 7) == 0) rx_feed.push_back(plain(ESCAPE_BYTE));
      rx_feed.push_back(plain(ESCAPE_BYTE));
      rx_feed.push_back(plain(v - 8'd1));
    end else begin
      rx_feed.push_back(plain(v));
    end
  endtask

  task automatic build_frame(input bit go_long);
    int         len;
    int         pick;
    logic [7:0] v;
    logic [7:0] sum;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        v = 8'($urandom_range(0, 255));
        if (v == START_BYTE) v = 8'h00;
        rx_feed.push_back(plain(v));
      end
    end
    pick = $urandom_range(0, 99);
    if (go_long || pick == 0) len = 255;
    else if (pick == 1)
      len = ($urandom_range(0, 1) == 0) ? int'(ESCAPE_BYTE) : int'(START_BYTE);
    else if (pick == 2) len = $urandom_range(13, 254);
    else if (pick < 6) len = 0;
    else len = $urandom_range(1, 12);
    rx_feed.push_back(plain(START_BYTE));
    rx_feed.push_back(plain(len[7:0]));
    if (len == 0) return;
    sum = len[7:0];
    for (int i = 1; i < len; i++) begin
      if (!go_long && $urandom_range(0, 59) == 0) return;
      case ($urandom_range(0, 9))
        0:       v = START_BYTE;
        1:       v = ESCAPE_BYTE;
        2:       v = 8'h00;
        3:       v = 8'hFF;
        default: v = 8'($urandom_range(0, 255));
      endcase
      if (i == cmd_pos_q && $urandom_range(0, 1) == 0) v = exempt_cmd_q;
      push_coded(v);
      sum = sum + v;
    end
    push_coded(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : sum);
  endtask

  task automatic run_phase(input logic [7:0] exempt, input logic [7:0] pos, input int target,
                           input bit go_long);
    set_reg(CFG_EXEMPT_CMD, exempt);
    set_reg(CFG_CMD_POS, pos);
    settings_used++;
    build_frame(go_long);
    while (rx_feed.size() < target) build_frame(1'b0);
    send_feed();
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_EXEMPT_CMD;
    cfg_data_i    = 8'h00;
    exempt_cmd_q  = EXEMPT_CMD_RESET;
    cmd_pos_q     = CMD_POS_RESET;
    restart_hunt();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    rx_feed = '{
      pinned(8'h00, 1'b0, 8'h00, 8'd0, 1'b0, ST_OK),
      pinned(8'hFF, 1'b0, 8'h00, 8'd0, 1'b0, ST_OK),
      pinned(8'hE0, 1'b0, 8'h00, 8'd0, 1'b0, ST_OK),
      pinned(8'h00, 1'b1, 8'h00, 8'd0, 1'b1, ST_ZERO_LEN),
      plain(8'hE0),
      pinned(8'h01, 1'b1, 8'h01, 8'd0, 1'b0, ST_OK),
      pinned(8'h01, 1'b1, 8'h01, 8'd1, 1'b1, ST_OK),
      plain(8'hE0),
      plain(8'h04),
      plain(8'hE0),
      plain(8'hD0),
      plain(8'hD0),
      plain(8'hFF),
      plain(8'h63),
      pinned(8'h55, 1'b1, 8'h55, 8'd4, 1'b1, ST_EXEMPT),
      plain(8'hE0),
      plain(8'h02),
      plain(8'hD0),
      plain(8'h7F),
      plain(8'hD0),
      plain(8'h81),
      plain(8'hE0),
      plain(8'h02),
      plain(8'h10),
      pinned(8'h00, 1'b1, 8'h00, 8'd2, 1'b1, ST_CSUM_ERR)
    };
    send_feed();
    drain();

    run_phase(8'h00, 8'd1, 160, 1'b0);
    run_phase(8'hFF, 8'd254, 160, 1'b1);
    hold_off_req = 1'b1;
    run_phase(START_BYTE, 8'd2, 160, 1'b0);
    run_phase(ESCAPE_BYTE, 8'd5, 160, 1'b0);
    run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 12)), 160, 1'b0);
    run_phase(EXEMPT_CMD_RESET, CMD_POS_RESET, 160, 1'b0);

    $display("covered %0d input beats and %0d result beats over %0d register settings",
             beats_in, beats_out, settings_used);
    $display("frame ends: ok %0d, checksum error %0d, exempt %0d, zero length %0d",
             ends_by_status[ST_OK], ends_by_status[ST_CSUM_ERR],
             ends_by_status[ST_EXEMPT], ends_by_status[ST_ZERO_LEN]);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // switch each side between bursts and random gaps
  initial begin
    forever begin
      repeat ($urandom_range(60, 200)) @(negedge clk_i);
      tx_burst = ($urandom_range(0, 2) == 0);
      rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (300) begin
          @(negedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end
      stall = rx_burst ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  frame_beat_t got;
  frame_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data   = m_axis_tdata[7:0];
      got.index  = m_axis_tdata[15:8];
      got.last   = m_axis_tlast;
      got.status = status_e'(m_axis_tuser);
      beats_out++;
      if (got.last) ends_by_status[got.status]++;
      if (pending_beats.size() == 0) begin
        mismatches++;
        $display("%0t: expected no beat, got data %h index %0d last %b status %0d",
                 $time, got.data, got.index, got.last, got.status);
      end else begin
        want = pending_beats.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected data %h index %0d last %b status %0d, got data %h index %0d last %b status %0d",
                   $time, want.data, want.index, want.last, want.status,
                   got.data, got.index, got.last, got.status);
        end
      end
    end
  end

endmodule
